// ----- sv/rpi_pkg.sv -----
// Shared types and constants for the ray-plane intersection core.
`default_nettype none

package rpi_pkg;

  localparam int COORD_W = 32;
  localparam int NRM_W   = 18;
  localparam int DIFF_W  = 33;
  localparam int DPROD_W = 50;   // direction times normal
  localparam int NPROD_W = 51;   // origin offset times normal
  localparam int DEN_W   = 52;
  localparam int NUM_W   = 53;
  localparam int MAG_W   = 53;
  localparam int REM_W   = 54;
  localparam int QB      = 31;   // quotient bits below the saturation bit
  localparam int CFG_IDX_W = 3;

  localparam logic signed [NRM_W-1:0]   NORMAL_Z_RESET = 18'sd65536;
  localparam logic signed [COORD_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] DIST_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [NRM_W-1:0]   normal_x;
    logic signed [NRM_W-1:0]   normal_y;
    logic signed [NRM_W-1:0]   normal_z;
  } plane_t;

  // Members listed from the top bit down so origin_x lands in the lowest bits.
  typedef struct packed {
    logic signed [COORD_W-1:0] far_limit;
    logic signed [COORD_W-1:0] near_limit;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_x;
  } ray_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] near_limit;
    logic signed [COORD_W-1:0] far_limit;
  } window_t;

  // Word handed from one divider cell to the next.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] divisor;
    logic [QB-1:0]    dvd_lo;
    logic [QB-1:0]    quo;
    logic             neg;
    logic             sat;
    logic             den_zero;
    window_t          win;
  } cell_tok_t;

endpackage

`default_nettype wire

// ----- sv/rpi_cell.sv -----
// One restoring-division cell: produces one quotient bit per word.
`default_nettype none

module rpi_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire rpi_pkg::cell_tok_t  up_tok,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output rpi_pkg::cell_tok_t       dn_tok
);

  logic                      v_r;
  rpi_pkg::cell_tok_t        tok_r;
  rpi_pkg::cell_tok_t        tok_nxt;
  logic [rpi_pkg::REM_W-1:0] shifted;
  logic [rpi_pkg::REM_W-1:0] dvsr;
  logic                      ge;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_tok   = tok_r;

  always_comb begin
    dvsr    = rpi_pkg::REM_W'(up_tok.divisor);
    // bring down the next dividend bit
    shifted = {up_tok.rem[rpi_pkg::REM_W-2:0], up_tok.dvd_lo[rpi_pkg::QB-1]};
    ge      = (shifted >= dvsr);
    tok_nxt        = up_tok;
    tok_nxt.rem    = ge ? (shifted - dvsr) : shifted;
    tok_nxt.dvd_lo = {up_tok.dvd_lo[rpi_pkg::QB-2:0], 1'b0};
    tok_nxt.quo    = {up_tok.quo[rpi_pkg::QB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

  // Partial remainder stays below the divisor unless the quotient saturated.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !tok_r.sat |-> tok_r.rem < rpi_pkg::REM_W'(tok_r.divisor))
    else $error("divider cell remainder not below divisor");

endmodule

`default_nettype wire

// ----- sv/rpi_front.sv -----
// Front end: offsets, dot products, magnitudes and the overflow test ahead of the cells.
`default_nettype none

module rpi_front #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rpi_pkg::plane_t     plane,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rpi_pkg::ray_t       ray,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output rpi_pkg::cell_tok_t       dn_tok
);

  localparam int DVD_W = rpi_pkg::MAG_W + FRACTION_BITS;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  // stage 1: origin minus plane point
  logic signed [rpi_pkg::DIFF_W-1:0]  dfx_r, dfy_r, dfz_r;
  logic signed [rpi_pkg::COORD_W-1:0] dx_r, dy_r, dz_r;
  rpi_pkg::window_t                   w1_r;
  // stage 2: products
  logic signed [rpi_pkg::DPROD_W-1:0] pdx_r, pdy_r, pdz_r;
  logic signed [rpi_pkg::NPROD_W-1:0] pnx_r, pny_r, pnz_r;
  rpi_pkg::window_t                   w2_r;
  // stage 3: sums
  logic signed [rpi_pkg::DEN_W-1:0]   den_r, den_nxt;
  logic signed [rpi_pkg::NUM_W-1:0]   num_r, num_nxt;
  rpi_pkg::window_t                   w3_r;
  // stage 4: magnitudes and sign
  logic [rpi_pkg::MAG_W-1:0]          a_r, b_r, a_nxt, b_nxt;
  logic signed [rpi_pkg::MAG_W-1:0]   den_ext;
  logic                               neg_r, den_zero_r;
  rpi_pkg::window_t                   w4_r;
  // stage 5: cell entry word
  rpi_pkg::cell_tok_t                 tok_r, tok_nxt;
  logic [DVD_W-1:0]                   dvd;
  logic [rpi_pkg::REM_W-1:0]          rem0;

  assign en5      = !v5_r || dn_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign dn_valid = v5_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_comb begin
    den_nxt = rpi_pkg::DEN_W'(pdx_r) + rpi_pkg::DEN_W'(pdy_r) + rpi_pkg::DEN_W'(pdz_r);
    num_nxt = rpi_pkg::NUM_W'(pnx_r) + rpi_pkg::NUM_W'(pny_r) + rpi_pkg::NUM_W'(pnz_r);
    den_ext = rpi_pkg::MAG_W'(den_r);
    a_nxt   = num_r[rpi_pkg::NUM_W-1] ? rpi_pkg::MAG_W'(-num_r) : rpi_pkg::MAG_W'(num_r);
    b_nxt   = den_ext[rpi_pkg::MAG_W-1] ? rpi_pkg::MAG_W'(-den_ext)
                                        : rpi_pkg::MAG_W'(den_ext);
    // dividend is |num| scaled by the fraction; its top part seeds the remainder
    dvd  = {a_r, {FRACTION_BITS{1'b0}}};
    rem0 = rpi_pkg::REM_W'(dvd[DVD_W-1:rpi_pkg::QB]);
    tok_nxt.rem      = rem0;
    tok_nxt.divisor  = b_r;
    tok_nxt.dvd_lo   = dvd[rpi_pkg::QB-1:0];
    tok_nxt.quo      = '0;
    tok_nxt.neg      = neg_r;
    tok_nxt.sat      = (rem0 >= rpi_pkg::REM_W'(b_r));
    tok_nxt.den_zero = den_zero_r;
    tok_nxt.win      = w4_r;
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      dfx_r <= rpi_pkg::DIFF_W'(ray.origin_x) - rpi_pkg::DIFF_W'(plane.point_x);
      dfy_r <= rpi_pkg::DIFF_W'(ray.origin_y) - rpi_pkg::DIFF_W'(plane.point_y);
      dfz_r <= rpi_pkg::DIFF_W'(ray.origin_z) - rpi_pkg::DIFF_W'(plane.point_z);
      dx_r  <= ray.dir_x;
      dy_r  <= ray.dir_y;
      dz_r  <= ray.dir_z;
      w1_r.near_limit <= ray.near_limit;
      w1_r.far_limit  <= ray.far_limit;
    end
    if (en2 && v1_r) begin
      pdx_r <= rpi_pkg::DPROD_W'(dx_r * plane.normal_x);
      pdy_r <= rpi_pkg::DPROD_W'(dy_r * plane.normal_y);
      pdz_r <= rpi_pkg::DPROD_W'(dz_r * plane.normal_z);
      pnx_r <= rpi_pkg::NPROD_W'(dfx_r * plane.normal_x);
      pny_r <= rpi_pkg::NPROD_W'(dfy_r * plane.normal_y);
      pnz_r <= rpi_pkg::NPROD_W'(dfz_r * plane.normal_z);
      w2_r  <= w1_r;
    end
    if (en3 && v2_r) begin
      den_r <= den_nxt;
      num_r <= num_nxt;
      w3_r  <= w2_r;
    end
    if (en4 && v3_r) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      // the distance is -num/den: negative when both share a sign
      neg_r <= (num_r != '0) && (num_r[rpi_pkg::NUM_W-1] == den_r[rpi_pkg::DEN_W-1]);
      den_zero_r <= (den_r == '0);
      w4_r  <= w3_r;
    end
    if (en5 && v4_r) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ray_plane_intersection_core.sv -----
// Ray-plane intersection core: config registers, divider cell row and output stages.
// Pipeline: 5 front stages, 31 divider cells, a sign/saturate stage and the output register.
// Throughput: one ray per cycle unless out_tready back-pressure holds the pipeline; each
// divider cell resolves one quotient bit.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the plane
// registers with point 0 and normal (0, 0, 1.0).
`default_nettype none

module ray_plane_intersection_core #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, near_limit, far_limit
  input  wire logic [255:0]                      in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // distance
  output logic [31:0]                            out_tdata,
  // hit
  output logic [0:0]                             out_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rpi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  localparam logic [31:0] MISS_DIST = ~((32'd1 << FRACTION_BITS) - 32'd1);

  rpi_pkg::plane_t    plane_r;
  rpi_pkg::ray_t      ray;

  logic               link_v   [0:rpi_pkg::QB];
  logic               link_rdy [0:rpi_pkg::QB];
  rpi_pkg::cell_tok_t link_tok [0:rpi_pkg::QB];

  logic                              t1_v_r, out_v_r;
  logic                              en_t1, en_out;
  logic signed [rpi_pkg::COORD_W-1:0] d_r, d_nxt, dist_r;
  logic                              dz_r, hit_r, hit_nxt;
  rpi_pkg::window_t                  win_r;
  rpi_pkg::cell_tok_t                last_tok;

  assign cfg_ready = 1'b1;
  assign ray       = rpi_pkg::ray_t'(in_tdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.point_x  <= '0;
      plane_r.point_y  <= '0;
      plane_r.point_z  <= '0;
      plane_r.normal_x <= '0;
      plane_r.normal_y <= '0;
      plane_r.normal_z <= rpi_pkg::NORMAL_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpi_pkg::REG_POINT_X:  plane_r.point_x  <= cfg_data;
        rpi_pkg::REG_POINT_Y:  plane_r.point_y  <= cfg_data;
        rpi_pkg::REG_POINT_Z:  plane_r.point_z  <= cfg_data;
        rpi_pkg::REG_NORMAL_X: plane_r.normal_x <= cfg_data[rpi_pkg::NRM_W-1:0];
        rpi_pkg::REG_NORMAL_Y: plane_r.normal_y <= cfg_data[rpi_pkg::NRM_W-1:0];
        rpi_pkg::REG_NORMAL_Z: plane_r.normal_z <= cfg_data[rpi_pkg::NRM_W-1:0];
        default: ;
      endcase
    end
  end

  rpi_front #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .plane    (plane_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .ray      (ray),
    .dn_valid (link_v[0]),
    .dn_ready (link_rdy[0]),
    .dn_tok   (link_tok[0])
  );

  for (genvar i = 0; i < rpi_pkg::QB; i++) begin : g_cell
    rpi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_v[i]),
      .up_ready (link_rdy[i]),
      .up_tok   (link_tok[i]),
      .dn_valid (link_v[i+1]),
      .dn_ready (link_rdy[i+1]),
      .dn_tok   (link_tok[i+1])
    );
  end

  assign last_tok             = link_tok[rpi_pkg::QB];
  assign en_out               = !out_v_r || out_tready;
  assign en_t1                = !t1_v_r || en_out;
  assign link_rdy[rpi_pkg::QB] = en_t1;

  always_comb begin
    if (last_tok.sat) begin
      d_nxt = last_tok.neg ? rpi_pkg::DIST_MIN : rpi_pkg::DIST_MAX;
    end else if (last_tok.neg) begin
      d_nxt = -rpi_pkg::COORD_W'({1'b0, last_tok.quo});
    end else begin
      d_nxt = rpi_pkg::COORD_W'({1'b0, last_tok.quo});
    end
    hit_nxt = !dz_r && (d_r >= win_r.near_limit) && (d_r <= win_r.far_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_t1)  t1_v_r  <= link_v[rpi_pkg::QB];
      if (en_out) out_v_r <= t1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_t1 && link_v[rpi_pkg::QB]) begin
      d_r   <= d_nxt;
      dz_r  <= last_tok.den_zero;
      win_r <= last_tok.win;
    end
    if (en_out && t1_v_r) begin
      hit_r  <= hit_nxt;
      dist_r <= hit_nxt ? d_r : MISS_DIST;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = dist_r;
  assign out_tuser[0] = hit_r;

  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == MISS_DIST)
    else $error("miss word without the miss distance");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register empty");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result word present right after reset");

endmodule

`default_nettype wire
